// ===== hdl/cvsw_pkg.sv =====
// ----------------------------------------------------------------------------
// cvsw_pkg
// Shared types and constants for the convection scheme weight pipeline.
// ----------------------------------------------------------------------------
package cvsw_pkg;

    localparam int PQ_W = 40;   // widest Q.24 Peclet value over the parameter range
    localparam int X_W  = 34;   // exponent argument, Q.30, below 16
    localparam int U_W  = 30;   // series argument x/16, Q.30
    localparam int T_W  = 31;   // series term, Q.30, up to 1.0
    localparam int N_W  = 58;   // divider dividend
    localparam int D_W  = 39;   // divider divisor
    localparam int QB   = 18;   // quotient bits
    localparam int W_W  = 17;   // weight width

    localparam logic [2:0] SCH_BULG0   = 3'd0;
    localparam logic [2:0] SCH_CENTRAL = 3'd1;
    localparam logic [2:0] SCH_UPWIND  = 3'd2;
    localparam logic [2:0] SCH_HYBRID  = 3'd3;
    localparam logic [2:0] SCH_POWLAW  = 3'd4;
    localparam logic [2:0] SCH_EXPON   = 3'd5;
    localparam logic [2:0] SCH_BULG    = 3'd6;
    localparam logic [2:0] SCH_POWER   = 3'd7;
    localparam logic [2:0] SCH_RESET   = SCH_POWLAW;

    localparam logic [T_W-1:0]  ONE30 = 31'd1 << 30;
    localparam logic [W_W-1:0]  W_ONE = 17'd65536;

    localparam logic [PQ_W-1:0] PQ_1   = 40'd1 << 24;
    localparam logic [PQ_W-1:0] PQ_2   = 40'd2 << 24;
    localparam logic [PQ_W-1:0] PQ_10  = 40'd10 << 24;
    localparam logic [PQ_W-1:0] PQ_20  = 40'd20 << 24;
    localparam logic [PQ_W-1:0] PQ_512 = 40'd512 << 24;
    // smallest pq with pq*100 >= 2^24
    localparam logic [PQ_W-1:0] PQ_SMALL = 40'd167773;

    localparam logic [19:0] BULG_COEF   = 20'd703804;     // 0.6712 in Q.20
    localparam logic [29:0] LN_INV_0553 = 30'd636081739;  // ln(1/0.553) in Q.30
    localparam logic [30:0] RECIP5      = 31'((64'd1 << 33) / 5);

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_EXP,
        SRC_POW,
        SRC_BULG
    } t_src;

    typedef struct packed {
        t_src        src;
        logic [16:0] cval;
        logic [27:0] pqe;
        logic [37:0] dbul;
    } t_side;

    typedef struct packed {
        logic        use_div;
        logic [16:0] cval;
    } t_dside;

endpackage

// ===== hdl/cvsw_front.sv =====
// ----------------------------------------------------------------------------
// cvsw_front
// Range flags, half rule, power-law chain, Bulgakov denominator and exponent
// argument. Six register stages.
// ----------------------------------------------------------------------------
module cvsw_front
    import cvsw_pkg::*;
#(
    parameter int PE_FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [2:0]     i_scheme,
    input  logic           i_valid,
    input  logic [23:0]    i_peclet,
    output logic           o_valid,
    output logic [X_W-1:0] o_x,
    output t_side          o_side
);

    localparam int PQW   = 48 - PE_FRAC_BITS;
    localparam int SHIFT = 24 - PE_FRAC_BITS;

    typedef struct packed {
        logic lt1;
        logic lt2;
        logic lt10;
        logic lt20;
        logic lt512;
        logic small_p;
    } t_flags;

    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;

    logic [PQW-1:0] r1_pq;

    t_flags      r2_fl, r3_fl, r4_fl, r5_fl;
    logic [16:0] r2_half, r3_half, r4_half, r5_half;
    logic [27:0] r2_pqe, r3_pqe, r4_pqe, r5_pqe;
    logic [32:0] r2_vpl;
    logic [63:0] r2_mpl;
    logic [57:0] r2_pp;
    logic [58:0] r2_ymul;

    logic [30:0]    r3_r, r4_r, r5_r;
    logic [38:0]    r3_ph, r3_pl;
    logic [X_W-1:0] r3_x, r4_x, r5_x, r6_x;
    logic [30:0]    r4_r2, r5_r4;
    logic [37:0]    r4_d, r5_d;
    t_side          r6_side;

    // stage 2 inputs
    logic [PQ_W-1:0] pqx;
    logic [27:0]     a_pl;
    logic [32:0]     v_pl;
    logic [26:0]     hsum;
    t_flags          n_fl;

    // stage 3 inputs
    logic [30:0]    q0_pl;
    logic [33:0]    rem_pl;
    logic [30:0]    n_r;
    logic [37:0]    q_b;
    logic [X_W-1:0] y_pw;
    logic [X_W-1:0] n_x;

    // stage 4, 6 inputs
    logic [57:0] bsum;
    logic [30:0] p5;
    logic [16:0] plw;
    t_src        n_src;
    logic [16:0] n_cval;

    always_comb begin
        pqx          = PQ_W'(r1_pq);
        a_pl         = 28'(PQ_10) - pqx[27:0];
        v_pl         = {a_pl, 5'b0};
        hsum         = 27'(pqx[25:0]) + 27'd511;
        n_fl.lt1     = pqx < PQ_1;
        n_fl.lt2     = pqx < PQ_2;
        n_fl.lt10    = pqx < PQ_10;
        n_fl.lt20    = pqx < PQ_20;
        n_fl.lt512   = pqx < PQ_512;
        n_fl.small_p = pqx < PQ_SMALL;
    end

    // (10 - P) * 64 / 10 as a reciprocal multiply, then a one-step fixup
    always_comb begin
        q0_pl  = 31'(r2_mpl >> 33);
        rem_pl = 34'(r2_vpl) - 34'(q0_pl) * 34'd5;
        n_r    = (rem_pl >= 34'd5) ? q0_pl + 31'd1 : q0_pl;
        q_b    = 38'(r2_pp >> 20);
        y_pw   = X_W'(r2_ymul >> 24);
        if (i_scheme == SCH_EXPON && r2_fl.lt10 && !r2_fl.small_p) begin
            n_x = {r2_pqe, 6'b0};
        end else if (i_scheme == SCH_POWER && r2_fl.lt20) begin
            n_x = y_pw;
        end else begin
            n_x = '0;
        end
    end

    always_comb begin
        bsum = (58'(r3_ph) << 19) + 58'(r3_pl);
        p5   = 31'((62'(r5_r4) * 62'(r5_r)) >> 30);
        plw  = 17'(p5 >> 14);
    end

    always_comb begin
        n_src  = SRC_CONST;
        n_cval = '0;
        unique case (i_scheme)
            SCH_CENTRAL: begin
                if (r5_fl.lt1) n_cval = r5_half;
                else if (r5_fl.lt10) n_cval = plw;
            end
            SCH_UPWIND: begin
                n_cval = W_ONE;
            end
            SCH_HYBRID: begin
                if (r5_fl.lt2) n_cval = r5_half;
            end
            SCH_POWLAW: begin
                if (r5_fl.lt10) n_cval = plw;
            end
            SCH_EXPON: begin
                if (r5_fl.lt10) begin
                    if (r5_fl.small_p) n_cval = r5_half;
                    else n_src = SRC_EXP;
                end
            end
            SCH_POWER: begin
                if (r5_fl.lt20) n_src = SRC_POW;
            end
            default: begin
                if (r5_fl.lt512) n_src = SRC_BULG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pq   <= PQW'(i_peclet) << SHIFT;

            r2_fl   <= n_fl;
            r2_half <= 17'(18'd65536 - 18'(hsum >> 9));
            r2_pqe  <= pqx[27:0];
            r2_vpl  <= v_pl;
            r2_mpl  <= 64'(v_pl) * 64'(RECIP5);
            r2_pp   <= 58'(pqx[32:4]) * 58'(pqx[32:4]);
            r2_ymul <= 59'(pqx[28:0]) * 59'(LN_INV_0553);

            r3_fl   <= r2_fl;
            r3_half <= r2_half;
            r3_pqe  <= r2_pqe;
            r3_r    <= n_r;
            r3_ph   <= 39'(q_b[37:19]) * 39'(BULG_COEF);
            r3_pl   <= 39'(q_b[18:0]) * 39'(BULG_COEF);
            r3_x    <= n_x;

            r4_fl   <= r3_fl;
            r4_half <= r3_half;
            r4_pqe  <= r3_pqe;
            r4_r    <= r3_r;
            r4_r2   <= 31'((62'(r3_r) * 62'(r3_r)) >> 30);
            r4_d    <= 38'(bsum >> 20) + (38'd1 << 20);
            r4_x    <= r3_x;

            r5_fl   <= r4_fl;
            r5_half <= r4_half;
            r5_pqe  <= r4_pqe;
            r5_r    <= r4_r;
            r5_r4   <= 31'((62'(r4_r2) * 62'(r4_r2)) >> 30);
            r5_d    <= r4_d;
            r5_x    <= r4_x;

            r6_side.src  <= n_src;
            r6_side.cval <= n_cval;
            r6_side.pqe  <= r5_pqe;
            r6_side.dbul <= r5_d;
            r6_x         <= r5_x;
        end
    end

    assign o_valid = r6_valid;
    assign o_x     = r6_x;
    assign o_side  = r6_side;

endmodule

// ===== hdl/cvsw_exp.sv =====
// ----------------------------------------------------------------------------
// cvsw_exp
// e^-x in Q.30: twelve Horner steps on x/16 (three stages each: product,
// reciprocal multiply, fixup), then four squaring stages.
// ----------------------------------------------------------------------------
module cvsw_exp
    import cvsw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [X_W-1:0] i_x,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [T_W-1:0] o_e,
    output t_side          o_side
);

    localparam int STEPS = 12;
    localparam int SQ    = 4;
    localparam int LAT   = 3 * STEPS + SQ;

    logic [U_W-1:0] u_in [STEPS];
    logic [T_W-1:0] t_in [STEPS];

    logic [U_W-1:0] r_av [STEPS];
    logic [U_W-1:0] r_au [STEPS];
    logic [60:0]    r_bm [STEPS];
    logic [U_W-1:0] r_bv [STEPS];
    logic [U_W-1:0] r_bu [STEPS];
    logic [T_W-1:0] r_ct [STEPS];
    logic [U_W-1:0] r_cu [STEPS];
    logic [T_W-1:0] r_sq [SQ];

    logic  r_vld [LAT];
    t_side r_sd  [LAT];

    genvar g, s, j;

    generate
        for (g = 0; g < LAT; g++) begin : g_ctl
            if (g == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) r_vld[g] <= 1'b0;
                    else if (i_en) r_vld[g] <= i_valid;
                end
                always_ff @(posedge i_clk) begin
                    if (i_en) r_sd[g] <= i_side;
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) r_vld[g] <= 1'b0;
                    else if (i_en) r_vld[g] <= r_vld[g-1];
                end
                always_ff @(posedge i_clk) begin
                    if (i_en) r_sd[g] <= r_sd[g-1];
                end
            end
        end

        for (s = 0; s < STEPS; s++) begin : g_step
            localparam int K = STEPS - s;
            localparam logic [30:0] M = 31'((64'd1 << 30) / K);

            logic [U_W-1:0] q0;
            logic [33:0]    rem;
            logic [U_W-1:0] q;
            logic [T_W-1:0] n_ct;

            if (s == 0) begin : g_in0
                assign u_in[s] = i_x[X_W-1:4];
                assign t_in[s] = ONE30;
            end else begin : g_inn
                assign u_in[s] = r_cu[s-1];
                assign t_in[s] = r_ct[s-1];
            end

            // t = 1 - u*t/K, quotient by reciprocal with one correction
            always_comb begin
                q0   = U_W'(r_bm[s] >> 30);
                rem  = 34'(r_bv[s]) - 34'(q0) * 34'(K);
                q    = (rem >= 34'(K)) ? q0 + U_W'(1) : q0;
                n_ct = ONE30 - T_W'(q);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_av[s] <= U_W'((61'(u_in[s]) * 61'(t_in[s])) >> 30);
                    r_au[s] <= u_in[s];
                    r_bm[s] <= 61'(r_av[s]) * 61'(M);
                    r_bv[s] <= r_av[s];
                    r_bu[s] <= r_au[s];
                    r_ct[s] <= n_ct;
                    r_cu[s] <= r_bu[s];
                end
            end
        end

        for (j = 0; j < SQ; j++) begin : g_sq
            logic [T_W-1:0] sq_in;
            if (j == 0) begin : g_s0
                assign sq_in = r_ct[STEPS-1];
            end else begin : g_sn
                assign sq_in = r_sq[j-1];
            end
            always_ff @(posedge i_clk) begin
                if (i_en) r_sq[j] <= T_W'((62'(sq_in) * 62'(sq_in)) >> 30);
            end
        end
    endgenerate

    assign o_valid = r_vld[LAT-1];
    assign o_side  = r_sd[LAT-1];
    assign o_e     = r_sq[SQ-1];

endmodule

// ===== hdl/cvsw_div.sv =====
// ----------------------------------------------------------------------------
// cvsw_div
// Pipelined restoring divider: an overflow stage, then one quotient bit per
// stage. Quotient saturates at 1.0 in Q1.16.
// ----------------------------------------------------------------------------
module cvsw_div
    import cvsw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_n,
    input  logic [D_W-1:0] i_d,
    input  t_dside         i_side,
    output logic           o_valid,
    output logic [W_W-1:0] o_quot,
    output t_dside         o_side
);

    logic           r_vld [QB+1];
    t_dside         r_sd  [QB+1];
    logic           r_ovf [QB+1];
    logic [N_W-1:0] r_rem [QB];
    logic [D_W-1:0] r_d   [QB];
    logic [QB-1:0]  r_q   [QB];

    logic [QB-1:0] q_fin;

    genvar j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else if (i_en) r_vld[0] <= i_valid;
    end

    // quotient would not fit in QB bits (also catches a zero divisor)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0]  <= i_side;
            r_ovf[0] <= i_n >= (N_W'(i_d) << QB);
            r_rem[0] <= i_n;
            r_d[0]   <= i_d;
        end
    end

    generate
        for (j = 1; j <= QB; j++) begin : g_bit
            logic [N_W-1:0] sh;
            logic           bit_q;
            logic [N_W-1:0] n_rem;

            always_comb begin
                sh    = N_W'(r_d[j-1]) << (QB - j);
                bit_q = r_rem[j-1] >= sh;
                n_rem = bit_q ? r_rem[j-1] - sh : r_rem[j-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_vld[j] <= 1'b0;
                else if (i_en) r_vld[j] <= r_vld[j-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[j]  <= r_sd[j-1];
                    r_ovf[j] <= r_ovf[j-1];
                end
            end

            if (j == 1) begin : g_q0
                always_ff @(posedge i_clk) begin
                    if (i_en) r_q[0] <= QB'(bit_q);
                end
            end else begin : g_qn
                always_ff @(posedge i_clk) begin
                    if (i_en) r_q[j-1] <= {r_q[j-2][QB-2:0], bit_q};
                end
            end

            if (j < QB) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[j] <= n_rem;
                        r_d[j]   <= r_d[j-1];
                    end
                end
            end
        end
    endgenerate

    assign q_fin   = r_q[QB-1];
    assign o_valid = r_vld[QB];
    assign o_side  = r_sd[QB];
    assign o_quot  = (r_ovf[QB] || q_fin > QB'(W_ONE)) ? W_ONE : W_W'(q_fin);

endmodule

// ===== hdl/convection_scheme_weight.sv =====
// ----------------------------------------------------------------------------
// convection_scheme_weight
// Convection-diffusion weight A(|P|) for a selectable discretization scheme.
// ----------------------------------------------------------------------------
// One Peclet magnitude (unsigned, PE_FRAC_BITS fraction bits) in, one Q1.16
// weight out, one transfer per clock while the output is not stalled. Between
// input transfer and output valid: six front stages, 40 stages of the shared
// e^-x unit (twelve series steps of three stages plus four squarings), one
// product stage, 19 divider stages and the output register. Every item runs
// the full pipeline whatever the scheme. The scheme register is written
// through i_cfg_wr_en/i_cfg_wr_data and must only change while no item is
// in flight. A stalled output holds its item; input is still taken while the
// pipeline has an empty last stage.
// ----------------------------------------------------------------------------
module convection_scheme_weight
    import cvsw_pkg::*;
#(
    parameter int PE_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,   // scheme_select
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [23:0] peclet_magnitude
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [16:0] weight, [23:17] zero
);

    logic [2:0] r_scheme;

    logic           en;
    logic           fr_valid;
    logic [X_W-1:0] fr_x;
    t_side          fr_side;
    logic           ex_valid;
    logic [T_W-1:0] ex_e;
    t_side          ex_side;

    logic           r_m_valid;
    logic [N_W-1:0] r_m_n;
    logic [D_W-1:0] r_m_d;
    t_dside         r_m_side;
    logic [N_W-1:0] n_m_n;
    logic [D_W-1:0] n_m_d;
    t_dside         n_m_side;

    logic           dv_valid;
    logic [W_W-1:0] dv_quot;
    t_dside         dv_side;

    logic           r_out_valid;
    logic [W_W-1:0] r_out_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_scheme <= SCH_RESET;
        else if (i_cfg_wr_en) r_scheme <= i_cfg_wr_data;
    end

    assign en              = !dv_valid || !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    cvsw_front #(
        .PE_FRAC_BITS(PE_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_scheme (r_scheme),
        .i_valid  (i_s_axis_tvalid),
        .i_peclet (i_s_axis_tdata),
        .o_valid  (fr_valid),
        .o_x      (fr_x),
        .o_side   (fr_side)
    );

    cvsw_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_x     (fr_x),
        .i_side  (fr_side),
        .o_valid (ex_valid),
        .o_e     (ex_e),
        .o_side  (ex_side)
    );

    // dividend/divisor: P*E / ((1-E)*256) or 2^36 / d
    always_comb begin
        n_m_n            = '0;
        n_m_d            = D_W'(1);
        n_m_side.use_div = 1'b0;
        n_m_side.cval    = ex_side.cval;
        case (ex_side.src)
            SRC_EXP: begin
                n_m_n            = N_W'(59'(ex_side.pqe) * 59'(ex_e));
                n_m_d            = {ONE30 - ex_e, 8'b0};
                n_m_side.use_div = 1'b1;
            end
            SRC_BULG: begin
                n_m_n            = N_W'(1) << 36;
                n_m_d            = D_W'(ex_side.dbul);
                n_m_side.use_div = 1'b1;
            end
            SRC_POW: begin
                n_m_side.cval = W_W'(ex_e >> 14);
            end
            default: begin
                n_m_side.cval = ex_side.cval;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_valid <= 1'b0;
        else if (en) r_m_valid <= ex_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_n    <= n_m_n;
            r_m_d    <= n_m_d;
            r_m_side <= n_m_side;
        end
    end

    cvsw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m_valid),
        .i_n     (r_m_n),
        .i_d     (r_m_d),
        .i_side  (r_m_side),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (!r_out_valid || i_m_axis_tready) r_out_valid <= dv_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out_weight <= dv_side.use_div ? dv_quot : dv_side.cval;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_weight};

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_weight <= W_ONE)
        else $error("weight above 1.0");

    a_upwind_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_scheme == SCH_UPWIND) |-> r_out_weight == W_ONE)
        else $error("upwind weight not 1.0");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready && dv_valid) |-> !o_s_axis_tready)
        else $error("input taken while pipeline full and output stalled");

endmodule

// ===== tb/sv/cvsw_checker.sv =====
// ----------------------------------------------------------------------------
// cvsw_checker
// Watches both stream channels of the scheme weight block, computes the
// expected weight of every input transfer and compares output transfers in
// order against it.
// ----------------------------------------------------------------------------
module cvsw_checker
    import cvsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic [2:0]  scheme;
    logic [16:0] weight_q[$];

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] ONE_Q24 = 64'd1 << 24;

    function automatic logic [63:0] half_slope(logic [63:0] pq);
        return 64'd65536 - ((pq + 64'd511) >> 9);
    endfunction

    function automatic logic [63:0] fifth_power(logic [63:0] pq);
        logic [63:0] r, r2, r4, r5;
        r  = (((64'd10 * ONE_Q24) - pq) << 6) / 64'd10;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        r5 = (r4 * r) >> 30;
        return r5 >> 14;
    endfunction

    function automatic logic [63:0] decay_q30(logic [63:0] x);
        logic [63:0] u, t;
        u = x >> 4;
        t = ONE_Q30;
        for (int k = 12; k >= 1; k--)
            t = ONE_Q30 - ((u * t) >> 30) / k;
        for (int i = 0; i < 4; i++)
            t = (t * t) >> 30;
        return t;
    endfunction

    function automatic logic [16:0] scheme_weight(logic [2:0] sel, logic [23:0] mag);
        logic [63:0] pq, w, e, den, p, q, d, y;
        pq = 64'(mag) << (24 - 16);
        case (sel)
            SCH_CENTRAL: begin
                if (pq < ONE_Q24) w = half_slope(pq);
                else if (pq < 10 * ONE_Q24) w = fifth_power(pq);
                else w = 0;
            end
            SCH_UPWIND: w = 65536;
            SCH_HYBRID: w = (pq >= 2 * ONE_Q24) ? 0 : half_slope(pq);
            SCH_POWLAW: w = (pq < 10 * ONE_Q24) ? fifth_power(pq) : 0;
            SCH_EXPON: begin
                if (pq >= 10 * ONE_Q24) w = 0;
                else if (pq * 100 < ONE_Q24) w = half_slope(pq);
                else begin
                    e = decay_q30(pq << 6);
                    den = ONE_Q30 - e;
                    if (den == 0) w = 65536;
                    else begin
                        w = (pq * e) / (den << 8);
                        if (w > 65536) w = 65536;
                    end
                end
            end
            SCH_POWER: begin
                if (pq >= 20 * ONE_Q24) w = 0;
                else begin
                    y = (pq * 64'd636081739) >> 24;
                    w = decay_q30(y) >> 14;
                end
            end
            default: begin
                if (pq >= 512 * ONE_Q24) w = 0;
                else begin
                    p = pq >> 4;
                    q = (p * p) >> 20;
                    d = (64'd1 << 20) + ((q * 64'd703804) >> 20);
                    w = (64'd1 << 36) / d;
                end
            end
        endcase
        return w[16:0];
    endfunction

    assign o_pending = weight_q.size();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            scheme <= SCH_RESET;
            o_fail_count <= 0;
            weight_q.delete();
        end else begin
            if (i_cfg_wr_en) scheme <= i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready)
                weight_q.push_back(scheme_weight(scheme, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (weight_q.size() == 0) begin
                    $display("%0t: unexpected weight transfer, actual %0d", $time,
                             i_m_tdata[16:0]);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (i_m_tdata !== {7'd0, weight_q[0]}) begin
                        $display("%0t: weight expected %0d actual %0d (tdata %h)",
                                 $time, weight_q[0], i_m_tdata[16:0], i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(weight_q.pop_front());
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the scheme weight block: directed Peclet corner values under
// every scheme, random magnitudes under randomly picked schemes, random stalls
// on both sides and one long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top
    import cvsw_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          stall_free;
    bit          hold_off;

    localparam int LATENCY = 67;

    convection_scheme_weight #(.PE_FRAC_BITS(16)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    cvsw_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            m_tready <= stall_free || ($urandom_range(99) >= 24);
        end
    end

    task automatic send_mag(input logic [23:0] mag);
        s_tvalid <= 1;
        s_tdata  <= mag;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (!stall_free) begin
            while ($urandom_range(99) < 24) begin
                s_tvalid <= 0;
                @(negedge i_clk);
            end
        end
    endtask

    task automatic set_scheme(input logic [2:0] sel);
        s_tvalid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= sel;
        @(negedge i_clk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [23:0] random_mag();
        case ($urandom_range(5))
            0:       return 24'($urandom_range(65535));          // P < 1
            1:       return 24'($urandom_range(655359));         // P < 10
            2:       return 24'($urandom_range(1310719));        // P < 20
            3:       return 24'($urandom_range(2000));           // near 0.01
            default: return 24'($urandom);
        endcase
    endfunction

    logic [23:0] corners[] = '{24'd0, 24'd1, 24'd654, 24'd655, 24'd656,
        24'd32768, 24'd65535, 24'd65536, 24'd65537, 24'd131071, 24'd131072,
        24'd655359, 24'd655360, 24'd1310719, 24'd1310720, 24'h7FFFFF,
        24'hAAAAAA, 24'h555555, 24'hFFFFFF};
    logic [2:0] order[] = '{SCH_POWLAW, SCH_CENTRAL, SCH_UPWIND, SCH_HYBRID,
        SCH_EXPON, SCH_BULG, SCH_POWER, SCH_BULG0};

    initial begin
        i_rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = SCH_RESET;
        s_tvalid = 0;
        s_tdata = 0;
        stall_free = 0;
        hold_off = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // reset scheme first, then every scheme with the corner values
        foreach (order[s]) begin
            if (s != 0) set_scheme(order[s]);
            foreach (corners[i]) send_mag(corners[i]);
        end
        for (int ph = 0; ph < 8; ph++) begin
            set_scheme(order[$urandom_range(7)]);
            stall_free = (ph == 3);
            if (ph == 5) hold_off = 1;
            for (int n = 0; n < 90; n++) send_mag(random_mag());
        end
        stall_free = 0;
        s_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
